[hw/rtl/efpd_pkg.sv]
// Package for the encoder frame position decoder.
// Holds field widths, the operation code type and the frame helper functions.
// No dependencies.
package efpd_pkg;

    localparam int WORD_W     = 64;
    localparam int POS_W      = 34;
    localparam int CRC_W      = 6;
    localparam int CRC_DATA_W = 36;
    localparam int ANGLE_W    = 43;
    localparam int START_MIN  = 43;
    // Window below the start bit: CDS, position, error, warning and CRC.
    localparam int WIN_W      = 43;
    localparam int SHIFT_W    = 5;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 128;

    localparam logic [CRC_W-1:0] CRC6_TAPS = 6'h03;

    typedef enum logic {
        OP_DECODE   = 1'b0,
        OP_SET_ZERO = 1'b1
    } op_t;

    typedef struct packed {
        logic               found;
        logic [SHIFT_W-1:0] shift;
    } start_t;

    // Finds the highest set bit at or above the minimum start position and
    // returns the right shift that brings the window below it to bit 0.
    function automatic start_t find_start(input logic [WORD_W-1:0] w);
        start_t r;
        r.found = 1'b0;
        r.shift = '0;
        for (int k = START_MIN; k < WORD_W; k++) begin
            if (w[k]) begin
                r.found = 1'b1;
                r.shift = SHIFT_W'(k - START_MIN);
            end
        end
        return r;
    endfunction

    // CRC contribution of a single set data bit k positions above the end of
    // the message; it reduces to a constant once k is fixed.
    function automatic logic [CRC_W-1:0] crc6_column(input int k);
        logic [CRC_W-1:0] c;
        logic             top;
        c = CRC6_TAPS;
        for (int i = 0; i < k; i++) begin
            top = c[CRC_W-1];
            c   = {c[CRC_W-2:0], 1'b0};
            if (top) begin
                c = c ^ CRC6_TAPS;
            end
        end
        return c;
    endfunction

    // The CRC is linear with a zero seed, so it is the XOR of the columns of
    // all set data bits.
    function automatic logic [CRC_W-1:0] crc6_of36(input logic [CRC_DATA_W-1:0] d);
        logic [CRC_W-1:0] c;
        c = '0;
        for (int k = 0; k < CRC_DATA_W; k++) begin
            if (d[k]) begin
                c = c ^ crc6_column(k);
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/encoder_frame_position_decoder.sv]
// Throughput: one transaction per cycle; the stages are an input register, a start
// bit search and field extraction stage, and a CRC check and state update stage.
// Back-pressure on the result side stalls a full stage only while every stage after it is full.
// Reset (aresetn, synchronous, active low) empties the pipeline and clears all
// held frame fields, the zero offset and the held position.
module encoder_frame_position_decoder
    import efpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: frame_word[63:0], safe_to_zero[64], zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: operation[0].
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: frame_valid[0], position[34:1], raw_position[68:35],
    // error_bit[69], warning_bit[70], crc_received[76:71], crc_computed[82:77],
    // angle_fixed[125:83], zero_set_done[126], zero fill.
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Input register.
    logic              in_valid_reg;
    op_t               in_op_reg;
    logic              in_safe_reg;
    logic [WORD_W-1:0] in_word_reg;

    // Extraction stage.
    logic              ext_valid_reg;
    op_t               ext_op_reg;
    logic              ext_safe_reg;
    logic              ext_found_reg;
    logic [WIN_W-1:0]  ext_win_reg;

    // Held frame state, which also forms most of the result payload.
    logic               valid_hold_reg;
    logic [POS_W-1:0]   position_hold_reg;
    logic [POS_W-1:0]   raw_pos_hold_reg;
    logic               error_hold_reg;
    logic               warning_hold_reg;
    logic [CRC_W-1:0]   crc_recv_hold_reg;
    logic [CRC_W-1:0]   crc_calc_hold_reg;
    logic [POS_W-1:0]   zero_offset_reg;

    // Result register.
    logic               m_valid_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic               done_reg;

    logic               out_free;
    logic               ext_free;
    logic               ext_adv;
    logic               in_adv;
    logic               s_acc;
    start_t             start;
    logic [POS_W-1:0]   raw_new;
    logic               err_new;
    logic               warn_new;
    logic [CRC_W-1:0]   crc_rx_new;
    logic [CRC_W-1:0]   crc_calc_new;
    logic               frame_ok;
    logic [POS_W-1:0]   position_next;
    logic [ANGLE_W-1:0] pos_wide;
    logic [ANGLE_W-1:0] angle_next;

    assign out_free = !m_valid_reg || m_tready;
    assign ext_free = !ext_valid_reg || out_free;
    assign ext_adv  = ext_valid_reg && out_free;
    assign in_adv   = in_valid_reg && ext_free;
    assign s_tready = !in_valid_reg || ext_free;
    assign s_acc    = s_tvalid && s_tready;

    assign start = find_start(in_word_reg);

    assign raw_new      = ext_win_reg[41:8];
    assign err_new      = ext_win_reg[7];
    assign warn_new     = ext_win_reg[6];
    assign crc_rx_new   = ext_win_reg[5:0];
    assign crc_calc_new = crc6_of36(ext_win_reg[41:6]);

    // The received CRC is sent inverted.
    assign frame_ok = (ext_op_reg == OP_DECODE) && ext_found_reg && err_new
                      && ((~crc_calc_new) == crc_rx_new);

    assign position_next = frame_ok ? (raw_new - zero_offset_reg) : position_hold_reg;

    // Multiplying by 360 is 256 + 64 + 32 + 8.
    assign pos_wide   = ANGLE_W'(position_next);
    assign angle_next = (pos_wide << 8) + (pos_wide << 6) + (pos_wide << 5) + (pos_wide << 3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_acc) begin
            in_valid_reg <= 1'b1;
        end else if (in_adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_op_reg   <= op_t'(s_tuser[0]);
            in_safe_reg <= s_tdata[WORD_W];
            in_word_reg <= s_tdata[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_valid_reg <= 1'b0;
        end else if (in_adv) begin
            ext_valid_reg <= 1'b1;
        end else if (ext_adv) begin
            ext_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            ext_op_reg    <= in_op_reg;
            ext_safe_reg  <= in_safe_reg;
            ext_found_reg <= start.found;
            ext_win_reg   <= WIN_W'(in_word_reg >> start.shift);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_hold_reg    <= 1'b0;
            position_hold_reg <= '0;
            raw_pos_hold_reg  <= '0;
            error_hold_reg    <= 1'b0;
            warning_hold_reg  <= 1'b0;
            crc_recv_hold_reg <= '0;
            crc_calc_hold_reg <= '0;
            zero_offset_reg   <= '0;
        end else if (ext_adv) begin
            if (ext_op_reg == OP_DECODE) begin
                valid_hold_reg    <= frame_ok;
                position_hold_reg <= position_next;
                if (ext_found_reg) begin
                    raw_pos_hold_reg  <= raw_new;
                    error_hold_reg    <= err_new;
                    warning_hold_reg  <= warn_new;
                    crc_recv_hold_reg <= crc_rx_new;
                    crc_calc_hold_reg <= crc_calc_new;
                end
            end else if (ext_safe_reg) begin
                zero_offset_reg <= raw_pos_hold_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ext_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ext_adv) begin
            angle_reg <= angle_next;
            done_reg  <= (ext_op_reg == OP_SET_ZERO) && ext_safe_reg;
        end
    end

    // The held state only changes when a result is loaded, so it stays
    // stable while the result waits.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, done_reg, angle_reg, crc_calc_hold_reg, crc_recv_hold_reg,
                       warning_hold_reg, error_hold_reg, raw_pos_hold_reg,
                       position_hold_reg, valid_hold_reg};

`ifndef SYNTHESIS
    a_offset_only_by_set_zero: assert property (@(posedge aclk)
        (aresetn && $past(aresetn) && !$stable(zero_offset_reg))
        |-> $past(ext_adv && ext_op_reg == OP_SET_ZERO && ext_safe_reg))
        else $error("zero offset changed without a permitted set-zero transaction");

    a_set_zero_copies_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && done_reg) |-> (zero_offset_reg == raw_pos_hold_reg))
        else $error("set-zero result does not match the captured offset");

    a_valid_frame_checks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && valid_hold_reg)
        |-> (error_hold_reg && ((~crc_calc_hold_reg) == crc_recv_hold_reg)))
        else $error("frame reported valid with a failed CRC or error bit");

    a_angle_tracks_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (angle_reg == ANGLE_W'(ANGLE_W'(position_hold_reg) * ANGLE_W'(360))))
        else $error("angle does not match the held position");
`endif

endmodule

[test/efpd_checker.sv]
`timescale 1ns / 1ps
// Checker for the encoder frame position decoder: watches both stream channels,
// predicts each result from the accepted input transactions and compares it.
// Depends on efpd_pkg for widths and the operation codes.
module efpd_checker
    import efpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // Fields from bit 0: frame_word[63:0], safe_to_zero[64], zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: operation[0].
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: frame_valid, position, raw_position, error_bit,
    // warning_bit, crc_received, crc_computed, angle_fixed, zero_set_done.
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   outstanding
);

    // Declared from the highest bit down, so it overlays m_tdata directly.
    typedef struct packed {
        logic               fill;
        logic               zero_set_done;
        logic [ANGLE_W-1:0] angle_fixed;
        logic [CRC_W-1:0]   crc_computed;
        logic [CRC_W-1:0]   crc_received;
        logic               warning_bit;
        logic               error_bit;
        logic [POS_W-1:0]   raw_position;
        logic [POS_W-1:0]   position;
        logic               frame_valid;
    } frame_report_t;

    frame_report_t expected_reports[$];

    // Mirror of the decoder's held state.
    logic [POS_W-1:0] raw_hold;
    logic [POS_W-1:0] zero_offset;
    logic [POS_W-1:0] pos_hold;
    logic             err_hold;
    logic             warn_hold;
    logic             valid_hold;
    logic [CRC_W-1:0] crc_rcv_hold;
    logic [CRC_W-1:0] crc_calc_hold;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Bit-serial CRC-6, most significant data bit first, zero seed.
    function automatic logic [CRC_W-1:0] crc6_serial(input logic [CRC_DATA_W-1:0] d);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = '0;
        for (int k = CRC_DATA_W - 1; k >= 0; k--) begin
            fb = d[k] ^ c[CRC_W-1];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC6_TAPS;
            end
        end
        return c;
    endfunction

    task automatic decode_frame(input logic [WORD_W-1:0] w);
        int                       top;
        logic [WORD_W-1:0]        win;
        logic [CRC_DATA_W-1:0]    data;
        top = -1;
        for (int k = 0; k < WORD_W; k++) begin
            if (w[k]) begin
                top = k;
            end
        end
        if (top < START_MIN) begin
            valid_hold = 1'b0;
        end else begin
            // The start bit lands on bit 43 of the window; the CRC sits at the bottom.
            win           = w >> (top - WIN_W);
            raw_hold      = win[41:8];
            err_hold      = win[7];
            warn_hold     = win[6];
            crc_rcv_hold  = win[5:0];
            data          = win[41:6];
            crc_calc_hold = crc6_serial(data);
            if ((~crc_calc_hold) == crc_rcv_hold && err_hold) begin
                valid_hold = 1'b1;
                pos_hold   = raw_hold - zero_offset;
            end else begin
                valid_hold = 1'b0;
            end
        end
    endtask

    task automatic predict_report(input logic op_bit, input logic [WORD_W-1:0] w,
                                  input logic safe, output frame_report_t r);
        logic [63:0] angle;
        r = '0;
        if (op_t'(op_bit) == OP_DECODE) begin
            decode_frame(w);
        end else if (safe) begin
            zero_offset     = raw_hold;
            r.zero_set_done = 1'b1;
        end
        angle          = 64'(pos_hold) * 64'd360;
        r.frame_valid  = valid_hold;
        r.position     = pos_hold;
        r.raw_position = raw_hold;
        r.error_bit    = err_hold;
        r.warning_bit  = warn_hold;
        r.crc_received = crc_rcv_hold;
        r.crc_computed = crc_calc_hold;
        r.angle_fixed  = angle[ANGLE_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : monitor
        frame_report_t got;
        frame_report_t want;
        if (!aresetn) begin
            raw_hold      = '0;
            zero_offset   = '0;
            pos_hold      = '0;
            err_hold      = 1'b0;
            warn_hold     = 1'b0;
            valid_hold    = 1'b0;
            crc_rcv_hold  = '0;
            crc_calc_hold = '0;
            expected_reports.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result transaction with nothing expected, got %0h",
                                 $realtime, m_tdata);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    check_field("frame_valid", 64'(want.frame_valid), 64'(got.frame_valid));
                    check_field("position", 64'(want.position), 64'(got.position));
                    check_field("raw_position", 64'(want.raw_position),
                                64'(got.raw_position));
                    check_field("error_bit", 64'(want.error_bit), 64'(got.error_bit));
                    check_field("warning_bit", 64'(want.warning_bit), 64'(got.warning_bit));
                    check_field("crc_received", 64'(want.crc_received),
                                64'(got.crc_received));
                    check_field("crc_computed", 64'(want.crc_computed),
                                64'(got.crc_computed));
                    check_field("angle_fixed", 64'(want.angle_fixed), 64'(got.angle_fixed));
                    check_field("zero_set_done", 64'(want.zero_set_done),
                                64'(got.zero_set_done));
                end
            end
            if (s_tvalid && s_tready) begin
                predict_report(s_tuser[0], s_tdata[WORD_W-1:0], s_tdata[WORD_W], want);
                expected_reports.push_back(want);
            end
            outstanding <= expected_reports.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the encoder frame position decoder: clock, reset, directed and
// random frame stimulus, random back-pressure and the final verdict.
// Depends on efpd_pkg, the decoder RTL and efpd_checker.
module tb;
    import efpd_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 200000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   mismatches;
    int                   outstanding;
    int                   cycles;
    bit                   quiet;

    encoder_frame_position_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    efpd_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        quiet    = 1'b0;
        cycles   = 0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver stalls with a probability of about nine percent outside the quiet stretch.
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 9);
    end

    // Builds a received word with its start bit at position s; the bits below the
    // CRC are filled with junk, which the decoder must ignore.
    function automatic logic [WORD_W-1:0] build_frame(input int s, input logic [POS_W-1:0] pos,
                                                      input logic err, input logic warn,
                                                      input logic cds, input logic crc_good);
        logic [WORD_W-1:0]     w;
        logic [WORD_W-1:0]     junk;
        logic [CRC_DATA_W-1:0] d;
        logic [CRC_W-1:0]      crc;
        d   = {pos, err, warn};
        crc = ~crc6_of36(d);
        if (!crc_good) begin
            crc = crc ^ CRC_W'($urandom_range(1, 63));
        end
        junk = {$urandom, $urandom};
        w    = 64'd1 << s;
        w    = w | (64'(cds) << (s - 1));
        w    = w | (64'(d) << (s - 37));
        w    = w | (64'(crc) << (s - 43));
        if (s > START_MIN) begin
            w = w | (junk & ((64'd1 << (s - 43)) - 64'd1));
        end
        return w;
    endfunction

    function automatic logic [POS_W-1:0] random_pos();
        return {2'($urandom_range(0, 3)), 32'($urandom)};
    endfunction

    // Presents one transaction, waits for its acceptance and then, outside the quiet stretch, idles at random.
    task automatic send_item(input op_t op, input logic [WORD_W-1:0] w, input logic safe);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, safe, w};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        if (!quiet) begin
            while ($urandom_range(0, 99) < 9) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        int               pick;
        logic [WORD_W-1:0] w;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty word, and a word whose start bit is one short of the minimum.
        send_item(OP_DECODE, 64'd0, 1'b1);
        send_item(OP_DECODE, 64'h0000_07FF_FFFF_FFFF, 1'b1);
        // Lowest and highest start positions, largest and smallest position.
        send_item(OP_DECODE, build_frame(43, 34'h3_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
        send_item(OP_DECODE, build_frame(63, 34'h0, 1'b1, 1'b0, 1'b0, 1'b1), 1'b0);
        // Zero setting refused by the interlock, then permitted.
        send_item(OP_SET_ZERO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(OP_DECODE, build_frame(50, 34'h1_2345_6789, 1'b1, 1'b0, 1'b1, 1'b1), 1'b0);
        send_item(OP_SET_ZERO, 64'd0, 1'b1);
        // A position below the offset wraps round; an equal one gives zero.
        send_item(OP_DECODE, build_frame(55, 34'h10, 1'b1, 1'b1, 1'b0, 1'b1), 1'b0);
        send_item(OP_DECODE, build_frame(47, 34'h1_2345_6789, 1'b1, 1'b0, 1'b0, 1'b1), 1'b1);
        // Bad CRC, then a good CRC with the error bit low.
        send_item(OP_DECODE, build_frame(60, random_pos(), 1'b1, 1'b0, 1'b0, 1'b0), 1'b0);
        send_item(OP_DECODE, build_frame(44, random_pos(), 1'b0, 1'b1, 1'b1, 1'b1), 1'b0);
        // Offset taken from the raw position of a rejected frame.
        send_item(OP_SET_ZERO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_item(OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(OP_DECODE, 64'h8000_0000_0000_0000, 1'b0);
        send_item(OP_DECODE, 64'h0000_0800_0000_0000, 1'b0);
        send_item(OP_DECODE, build_frame(52, random_pos(), 1'b1, 1'b1, 1'b0, 1'b1), 1'b0);
        // A short word after a valid frame keeps the position but drops validity.
        send_item(OP_DECODE, 64'h0000_0000_1234_5678, 1'b1);
        send_item(OP_SET_ZERO, 64'd0, 1'b0);
        send_item(OP_DECODE, build_frame(63, 34'h3_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
        send_item(OP_SET_ZERO, 64'd0, 1'b1);
        send_item(OP_DECODE, build_frame(58, 34'h0, 1'b1, 1'b0, 1'b1, 1'b1), 1'b0);
        send_item(OP_DECODE, build_frame(45, 34'h3_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1), 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 400 && i < 600);
            if (i == 700) begin
                drain();
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                w = build_frame($urandom_range(43, 63), random_pos(),
                                $urandom_range(0, 99) < 90, $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 99) < 85);
                send_item(OP_DECODE, w, $urandom_range(0, 1));
            end else if (pick < 82) begin
                send_item(OP_SET_ZERO, {$urandom, $urandom}, $urandom_range(0, 1));
            end else if (pick < 92) begin
                send_item(OP_DECODE, {$urandom, $urandom}, $urandom_range(0, 1));
            end else begin
                // Shifted far enough that the start bit falls below the minimum.
                w = {$urandom, $urandom};
                send_item(OP_DECODE, w >> $urandom_range(21, 64), $urandom_range(0, 1));
            end
        end
        quiet = 1'b0;

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
